/* rtl/function_call_return_tracer_core_defines.svh */
`ifndef FUNCTION_CALL_RETURN_TRACER_CORE_DEFINES_SVH
`define FUNCTION_CALL_RETURN_TRACER_CORE_DEFINES_SVH

// Concurrent check on clk_i, quiet while rst_ni is low
`define FCRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication form of the check above
`define FCRT_ASSERT_IMP(lbl, ante, cons, msg) \
  `FCRT_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

/* rtl/fcrt_pkg.sv */
package fcrt_pkg;

  localparam int unsigned SymbolSlotsDef = 256;
  localparam int unsigned TailDepthDef   = 16;
  localparam int unsigned AddrBits       = 32;
  localparam int unsigned SymCountBits   = 9;
  localparam int unsigned SlotOutBits    = 8;
  localparam int unsigned IndexBits      = 8;
  localparam int unsigned DepthBits      = 8;
  localparam logic [DepthBits-1:0] DepthMax = 8'd255;
  localparam logic [DepthBits-1:0] DepthMin = 8'd2;
  localparam logic [DepthBits-1:0] IndentOff = 8'd3;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_CALL = 2'd1,
    OP_RET  = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic {
    CFG_PRESENT = 1'b0,
    CFG_COUNT   = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    REC_CALL = 1'b0,
    REC_RET  = 1'b1
  } rec_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_EMIT
  } back_state_e;

  typedef enum logic [1:0] {
    PH_CALL,
    PH_RET,
    PH_TOP
  } phase_e;

  typedef struct packed {
    op_e                   op;
    logic [AddrBits-1:0]   pc;
    logic [AddrBits-1:0]   target;
    logic                  tail;
    logic [IndexBits-1:0]  idx;
    logic [AddrBits-1:0]   start;
    logic [31:0]           length;
    logic                  func;
  } item_t;

endpackage

/* rtl/fcrt_ram.sv */
module fcrt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/fcrt_front.sv */
module fcrt_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  present_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  fcrt_pkg::item_t       in_item_i,
  output logic                  q_valid_o,
  input  logic                  q_pop_i,
  output fcrt_pkg::item_t       q_item_o
);

  fcrt_pkg::item_t buf_q [2];
  logic            wr_q, wr_d, rd_q, rd_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            take, keep, pop;

  assign in_stall_o = (cnt_q == 2'd2);
  assign take       = in_valid_i && !in_stall_o;
  // drop ignored operations at the door
  assign keep = take && (in_item_i.op == fcrt_pkg::OP_LOAD ||
                         (present_i && (in_item_i.op == fcrt_pkg::OP_CALL ||
                                        in_item_i.op == fcrt_pkg::OP_RET)));
  assign pop       = q_pop_i && (cnt_q != 2'd0);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o  = buf_q[rd_q];

  always_comb begin
    wr_d  = wr_q ^ keep;
    rd_d  = rd_q ^ pop;
    cnt_d = cnt_q + {1'b0, keep} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (keep) begin
      buf_q[wr_q] <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* rtl/fcrt_back.sv */
`include "function_call_return_tracer_core_defines.svh"

module fcrt_back #(
  parameter int unsigned SymbolSlots = fcrt_pkg::SymbolSlotsDef,
  parameter int unsigned TailDepth   = fcrt_pkg::TailDepthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [fcrt_pkg::SymCountBits-1:0] count_i,
  input  logic                   q_valid_i,
  output logic                   q_pop_o,
  input  fcrt_pkg::item_t        q_item_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   record_kind_o,
  output logic [31:0]            record_pc_o,
  output logic [31:0]            record_target_o,
  output logic [7:0]             indent_level_o,
  output logic                   symbol_found_o,
  output logic [7:0]             symbol_slot_o,
  output logic                   stack_overflow_o,
  output logic                   last_record_o
);

  localparam int unsigned AW    = fcrt_pkg::AddrBits;
  localparam int unsigned SlotW = (SymbolSlots > 1) ? $clog2(SymbolSlots) : 1;
  localparam int unsigned ScanW = ($clog2(SymbolSlots + 1) > fcrt_pkg::SymCountBits) ?
                                  $clog2(SymbolSlots + 1) : fcrt_pkg::SymCountBits;
  localparam int unsigned FillW = $clog2(TailDepth + 1);
  localparam int unsigned TopW  = (TailDepth > 1) ? $clog2(TailDepth) : 1;
  localparam int unsigned NW    = $clog2(TailDepth + 2);
  localparam int unsigned RamW  = 2 * AW + 1;

  fcrt_pkg::back_state_e state_q, state_d;
  fcrt_pkg::phase_e      phase_q, phase_d;

  fcrt_pkg::item_t       cur_q, cur_d;
  logic [fcrt_pkg::DepthBits-1:0] depth_q, depth_d, depth_inc;
  logic [FillW-1:0]      fill_q, fill_d;
  logic [AW-1:0]         stk_pc_q  [TailDepth];
  logic [AW-1:0]         stk_dst_q [TailDepth];
  logic                  push;
  logic [TopW-1:0]       top;

  logic [AW-1:0]         key_q, key_d;
  logic                  exact_q, exact_d;
  logic [ScanW-1:0]      scan_q, scan_d;
  logic                  pend_q, pend_d;
  logic [SlotW-1:0]      cmp_q, cmp_d;
  logic                  issue, hit, miss, done, match;

  logic                  rec_kind_q, rec_kind_d;
  logic [AW-1:0]         rec_pc_q, rec_pc_d, rec_tgt_q, rec_tgt_d;
  logic [7:0]            rec_ind_q, rec_ind_d;
  logic                  rec_found_q, rec_found_d;
  logic [SlotW-1:0]      rec_slot_q, rec_slot_d;
  logic                  rec_ovf_q, rec_ovf_d, rec_last_q, rec_last_d;
  logic                  cont_q, cont_d, same;
  logic [NW-1:0]         n_q, n_d;

  logic                  out_valid_q, out_valid_d, out_free;

  logic                  ram_we;
  logic [SlotW-1:0]      ram_raddr;
  logic [RamW-1:0]       ram_wdata, ram_rdata;
  logic [AW-1:0]         ent_start;
  logic [31:0]           ent_len;
  logic                  ent_func;

  fcrt_ram #(
    .Width (RamW),
    .Depth (SymbolSlots)
  ) u_sym (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (SlotW'(q_item_i.idx)),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ram_wdata = {q_item_i.func, q_item_i.length, q_item_i.start};
  assign {ent_func, ent_len, ent_start} = ram_rdata;
  assign ram_raddr = SlotW'(scan_q);

  assign match = ent_func && (exact_q ? (ent_start == key_q) :
                 (key_q >= ent_start && (key_q - ent_start) < ent_len));
  assign issue = (state_q == fcrt_pkg::B_SCAN) && !(pend_q && match) &&
                 (scan_q < ScanW'(count_i)) && (scan_q < ScanW'(SymbolSlots));
  assign hit   = (state_q == fcrt_pkg::B_SCAN) && pend_q && match;
  assign miss  = (state_q == fcrt_pkg::B_SCAN) && !pend_q && !issue;
  assign done  = hit || miss;
  assign same  = (hit == rec_found_q) && (!hit || cmp_q == rec_slot_q);
  assign top   = TopW'(fill_q - FillW'(1));
  assign out_free  = !out_valid_q || !out_stall_i;
  assign depth_inc = (depth_q < fcrt_pkg::DepthMax) ? depth_q + 8'd1 : depth_q;
  assign q_pop_o   = (state_q == fcrt_pkg::B_IDLE) && q_valid_i;
  assign ram_we    = q_pop_o && (q_item_i.op == fcrt_pkg::OP_LOAD) &&
                     (32'(q_item_i.idx) < SymbolSlots);
  assign push      = done && (phase_q == fcrt_pkg::PH_CALL) && cur_q.tail &&
                     (fill_q < FillW'(TailDepth));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fcrt_pkg::B_IDLE: begin
        if (q_valid_i) begin
          if (q_item_i.op == fcrt_pkg::OP_CALL && depth_inc > fcrt_pkg::DepthMin) begin
            state_d = fcrt_pkg::B_SCAN;
          end else if (q_item_i.op == fcrt_pkg::OP_RET && depth_q > fcrt_pkg::DepthMin) begin
            state_d = fcrt_pkg::B_SCAN;
          end
        end
      end
      fcrt_pkg::B_SCAN: begin
        if (done && !(phase_q == fcrt_pkg::PH_RET && fill_q != '0)) begin
          state_d = fcrt_pkg::B_EMIT;
        end
      end
      fcrt_pkg::B_EMIT: begin
        if (out_free) begin
          state_d = cont_q ? fcrt_pkg::B_SCAN : fcrt_pkg::B_IDLE;
        end
      end
      default: state_d = fcrt_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    phase_d = phase_q;  cur_d = cur_q;  depth_d = depth_q;  fill_d = fill_q;
    key_d = key_q;  exact_d = exact_q;  scan_d = scan_q;  cmp_d = cmp_q;
    pend_d = issue;
    rec_kind_d = rec_kind_q;  rec_pc_d = rec_pc_q;  rec_tgt_d = rec_tgt_q;
    rec_ind_d = rec_ind_q;  rec_found_d = rec_found_q;  rec_slot_d = rec_slot_q;
    rec_ovf_d = rec_ovf_q;  rec_last_d = rec_last_q;  cont_d = cont_q;  n_d = n_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (issue) begin
      cmp_d  = SlotW'(scan_q);
      scan_d = scan_q + ScanW'(1);
    end
    unique case (state_q)
      fcrt_pkg::B_IDLE: begin
        scan_d = '0;
        pend_d = 1'b0;
        if (q_valid_i) begin
          cur_d = q_item_i;
          n_d   = '0;
          if (q_item_i.op == fcrt_pkg::OP_CALL) begin
            depth_d = depth_inc;
            phase_d = fcrt_pkg::PH_CALL;
            key_d   = q_item_i.target;
            exact_d = 1'b1;
          end else begin
            phase_d = fcrt_pkg::PH_RET;
            key_d   = q_item_i.pc;
            exact_d = 1'b0;
          end
        end
      end
      fcrt_pkg::B_SCAN: begin
        if (done) begin
          unique case (phase_q)
            fcrt_pkg::PH_CALL: begin
              rec_kind_d  = fcrt_pkg::REC_CALL;
              rec_pc_d    = cur_q.pc;
              rec_tgt_d   = cur_q.target;
              rec_ind_d   = depth_q - fcrt_pkg::IndentOff;
              rec_found_d = hit;
              rec_slot_d  = hit ? cmp_q : '0;
              rec_ovf_d   = cur_q.tail && !push;
              rec_last_d  = 1'b1;
              cont_d      = 1'b0;
              if (push) begin
                fill_d = fill_q + FillW'(1);
              end
            end
            fcrt_pkg::PH_RET: begin
              rec_kind_d  = fcrt_pkg::REC_RET;
              rec_pc_d    = key_q;
              rec_tgt_d   = '0;
              rec_ind_d   = depth_q - fcrt_pkg::IndentOff;
              rec_found_d = hit;
              rec_slot_d  = hit ? cmp_q : '0;
              rec_ovf_d   = 1'b0;
              rec_last_d  = 1'b1;
              cont_d      = 1'b0;
              depth_d     = depth_q - 8'd1;
              n_d         = n_q + NW'(1);
              if (fill_q != '0) begin
                phase_d = fcrt_pkg::PH_TOP;
                key_d   = stk_dst_q[top];
                exact_d = 1'b1;
                scan_d  = '0;
                pend_d  = 1'b0;
              end
            end
            fcrt_pkg::PH_TOP: begin
              if (same) begin
                fill_d     = fill_q - FillW'(1);
                cont_d     = (depth_q > fcrt_pkg::DepthMin) && (32'(n_q) <= TailDepth);
                rec_last_d = !cont_d;
                key_d      = stk_pc_q[top];
              end
            end
            default: ;
          endcase
        end
      end
      fcrt_pkg::B_EMIT: begin
        scan_d = '0;
        pend_d = 1'b0;
        if (out_free) begin
          out_valid_d = 1'b1;
          phase_d     = fcrt_pkg::PH_RET;
          exact_d     = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;  key_q <= key_d;  exact_q <= exact_d;  scan_q <= scan_d;
    cmp_q <= cmp_d;
    rec_kind_q <= rec_kind_d;  rec_pc_q <= rec_pc_d;  rec_tgt_q <= rec_tgt_d;
    rec_ind_q <= rec_ind_d;  rec_found_q <= rec_found_d;  rec_slot_q <= rec_slot_d;
    rec_ovf_q <= rec_ovf_d;  rec_last_q <= rec_last_d;  n_q <= n_d;
    if (push) begin
      stk_pc_q[TopW'(fill_q)]  <= cur_q.pc;
      stk_dst_q[TopW'(fill_q)] <= cur_q.target;
    end
    if (state_q == fcrt_pkg::B_EMIT && out_free) begin
      record_kind_o    <= rec_kind_q;
      record_pc_o      <= 32'(rec_pc_q);
      record_target_o  <= 32'(rec_tgt_q);
      indent_level_o   <= rec_ind_q;
      symbol_found_o   <= rec_found_q;
      symbol_slot_o    <= fcrt_pkg::SlotOutBits'(rec_slot_q);
      stack_overflow_o <= rec_ovf_q;
      last_record_o    <= rec_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fcrt_pkg::B_IDLE;
      phase_q     <= fcrt_pkg::PH_CALL;
      depth_q     <= '0;
      fill_q      <= '0;
      pend_q      <= 1'b0;
      cont_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      depth_q     <= depth_d;
      fill_q      <= fill_d;
      pend_q      <= pend_d;
      cont_q      <= cont_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `FCRT_ASSERT(a_fill_bound, (32'(fill_q) <= TailDepth), "tail stack fill beyond depth")
  `FCRT_ASSERT_IMP(a_pop_only_on_match, (fill_q < $past(fill_q)),
                   ($past(phase_q) == fcrt_pkg::PH_TOP && $past(done)), "unexpected pop")
  `FCRT_ASSERT_IMP(a_no_scan_on_load, (ram_we), (state_q == fcrt_pkg::B_IDLE),
                   "symbol write outside idle")
  `FCRT_ASSERT_IMP(a_emit_needs_record, (out_valid_q && !$past(out_valid_q)),
                   ($past(state_q) == fcrt_pkg::B_EMIT), "record without emit")

endmodule

/* rtl/function_call_return_tracer_core.sv */
// Call and return tracer. Load requests fill the symbol RAM; call and return
// requests produce trace records. Each symbol lookup walks the symbol RAM from
// slot 0, one slot per cycle through its single read port, and covers at most
// min(symbol_count, SymbolSlots) slots, fewer on an early hit. A call takes
// one lookup, a return record one or two (the second checks the tail stack
// top). A two-entry request queue and an output register let both sides
// stall independently.
module function_call_return_tracer_core #(
  parameter int unsigned SymbolSlots = fcrt_pkg::SymbolSlotsDef,
  parameter int unsigned TailDepth   = fcrt_pkg::TailDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [8:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [31:0] event_pc_i,
  input  logic [31:0] call_target_i,
  input  logic        tail_call_i,
  input  logic [7:0]  entry_index_i,
  input  logic [31:0] entry_start_i,
  input  logic [31:0] entry_length_i,
  input  logic        entry_is_function_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        record_kind_o,
  output logic [31:0] record_pc_o,
  output logic [31:0] record_target_o,
  output logic [7:0]  indent_level_o,
  output logic        symbol_found_o,
  output logic [7:0]  symbol_slot_o,
  output logic        stack_overflow_o,
  output logic        last_record_o
);

  logic                  present_q, present_d;
  logic [8:0]            count_q, count_d;
  fcrt_pkg::item_t       in_item, q_item;
  logic                  q_valid, q_pop;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    present_d = present_q;
    count_d   = count_q;
    if (cfg_valid_i) begin
      unique case (fcrt_pkg::cfg_idx_e'(cfg_index_i))
        fcrt_pkg::CFG_PRESENT: present_d = cfg_data_i[0];
        fcrt_pkg::CFG_COUNT:   count_d   = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= 1'b0;
      count_q   <= '0;
    end else begin
      present_q <= present_d;
      count_q   <= count_d;
    end
  end

  assign in_item = '{op:     fcrt_pkg::op_e'(op_i),
                     pc:     event_pc_i,
                     target: call_target_i,
                     tail:   tail_call_i,
                     idx:    entry_index_i,
                     start:  entry_start_i,
                     length: entry_length_i,
                     func:   entry_is_function_i};

  fcrt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .present_i  (present_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_item_o   (q_item)
  );

  fcrt_back #(
    .SymbolSlots (SymbolSlots),
    .TailDepth   (TailDepth)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .count_i          (count_q),
    .q_valid_i        (q_valid),
    .q_pop_o          (q_pop),
    .q_item_i         (q_item),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .record_kind_o    (record_kind_o),
    .record_pc_o      (record_pc_o),
    .record_target_o  (record_target_o),
    .indent_level_o   (indent_level_o),
    .symbol_found_o   (symbol_found_o),
    .symbol_slot_o    (symbol_slot_o),
    .stack_overflow_o (stack_overflow_o),
    .last_record_o    (last_record_o)
  );

endmodule
